FILE: rtl/itdt_pkg.sv
// Shared types and constants for the integer-to-decimal-text converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package itdt_pkg;

  localparam int unsigned DIG_BITS  = 4;
  localparam int unsigned CHAR_BITS = 6;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

  typedef logic [DIG_BITS-1:0] digit_t;

  // Per-cycle control broadcast to every BCD digit lane
  typedef struct packed {
    logic clear;      // start of conversion
    logic bit_shift;  // double-dabble step: add-3 then shift one bit in
    logic dig_shift;  // move one whole digit towards the top lane
  } itdt_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/int_to_decimal_text.sv
// Sequence: accept, VALUE_BITS double-dabble steps, an optional sign beat, then the
// digit slots from the top (leading zeros skipped without a beat), held by out_stall_i.
// A new value is taken only once the digit read-out is through, not during the BCD pass;
// a new value is taken while the final beat waits.
// Reset: asynchronous active low; returns to idle with the output empty.
`timescale 1ns / 1ps
`default_nettype none
module int_to_decimal_text
  import itdt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire signed [VALUE_BITS-1:0] value_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [CHAR_BITS-1:0]       ascii_code_o,
  output logic                       last_o
);

  // decimal digits needed: floor(bits * log10(2)) + 1, with log10(2) approximated by 77/256
  localparam int unsigned DIGITS = (VALUE_BITS * 77) / 256 + 1;
  localparam int unsigned BW     = $clog2(VALUE_BITS);
  localparam int unsigned CW     = $clog2(DIGITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SIGN, S_EMIT} state_e;

  state_e                 state_q, state_d;
  logic [VALUE_BITS-1:0]  mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [BW-1:0]          bit_q, bit_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   seen_q, seen_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_BITS-1:0]   ascii_q, ascii_d;
  logic                   last_q, last_d;
  logic                   out_free;
  itdt_ctrl_t             ctrl;

  logic   [DIGITS-1:0]    carry;
  digit_t                 digit [DIGITS];
  digit_t                 top_dig;

  for (genvar i = 0; i < DIGITS; i++) begin : g_lane
    logic   cin;
    digit_t din;
    if (i == 0) begin : g_first
      assign cin = mag_q[VALUE_BITS-1];
      assign din = '0;
    end else begin : g_rest
      assign cin = carry[i-1];
      assign din = digit[i-1];
    end
    itdt_bcd_digit u_digit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .carry_i (cin),
      .digit_i (din),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  assign top_dig  = digit[DIGITS-1];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q && out_stall_i;
    ascii_d     = ascii_q;
    last_d      = last_q;
    ctrl        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          neg_d      = value_i[VALUE_BITS-1];
          mag_d      = value_i[VALUE_BITS-1] ?
                       (~value_i + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_i;
          bit_d      = BW'(VALUE_BITS - 1);
          ctrl.clear = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.bit_shift = 1'b1;
        mag_d          = {mag_q[VALUE_BITS-2:0], 1'b0};
        if (bit_q == '0) begin
          cnt_d   = CW'(DIGITS);
          seen_d  = 1'b0;
          state_d = neg_q ? S_SIGN : S_EMIT;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ascii_d     = CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (seen_q || (top_dig != '0) || (cnt_q == CW'(1))) begin
          if (out_free) begin
            out_valid_d    = 1'b1;
            ascii_d        = CHAR_ZERO + {2'b00, top_dig};
            last_d         = (cnt_q == CW'(1));
            seen_d         = 1'b1;
            ctrl.dig_shift = 1'b1;
            cnt_d          = cnt_q - 1'b1;
            if (cnt_q == CW'(1)) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          // leading zero: drop it without a beat
          ctrl.dig_shift = 1'b1;
          cnt_d          = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      bit_q       <= '0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mag_q       <= '0;
      ascii_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      mag_q       <= mag_d;
      ascii_q     <= ascii_d;
      last_q      <= last_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign ascii_code_o = ascii_q;
  assign last_o       = last_q;

`ifndef SYNTH
  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_CONV))
    else $error("accepted value did not start a conversion");

  a_conv_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV && bit_q == '0) |=> (state_q == S_SIGN || state_q == S_EMIT))
    else $error("conversion did not finish after its last step");

  a_digit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (top_dig <= 4'd9))
    else $error("BCD digit out of range during read-out");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((ascii_code_o == CHAR_MINUS) ||
                     (ascii_code_o >= CHAR_ZERO && ascii_code_o <= CHAR_ZERO + 6'd9)))
    else $error("output character is neither sign nor digit");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ascii_code_o == CHAR_MINUS) |-> !last_o)
    else $error("minus sign flagged as final beat");
`endif

endmodule
`default_nettype wire

FILE: rtl/itdt_bcd_digit.sv
// One BCD digit lane of the double-dabble converter.
// Depends on itdt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module itdt_bcd_digit
  import itdt_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  itdt_ctrl_t ctrl_i,
  input  wire        carry_i,
  input  digit_t     digit_i,
  output logic       carry_o,
  output digit_t     digit_o
);

  digit_t dig_q;
  digit_t dig_d;
  digit_t adj;

  // carry out depends only on this lane's own digit, so no carry ripples through the lanes
  always_comb begin
    adj     = (dig_q >= 4'd5) ? dig_q + 4'd3 : dig_q;
    carry_o = adj[3];
    dig_d   = dig_q;
    if (ctrl_i.clear) begin
      dig_d = '0;
    end else if (ctrl_i.bit_shift) begin
      dig_d = {adj[2:0], carry_i};
    end else if (ctrl_i.dig_shift) begin
      dig_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q <= '0;
    end else begin
      dig_q <= dig_d;
    end
  end

  assign digit_o = dig_q;

endmodule
`default_nettype wire
